// ===== design/los_pkg.sv =====
// Package for the layer occupancy statistics block: types, codes and constants.
`default_nettype none
package los_pkg;

    localparam int DEF_LAYER_COUNT = 28;
    localparam int DEF_MAX_EVENTS  = 1048576;
    localparam int CENTRE_COUNT    = 28;
    localparam int IDX_W           = 7;
    localparam int SUM_W           = 36;
    localparam int SQ_W            = 52;
    localparam int EVT_W           = 21;

    localparam logic [1:0] CMD_HIT      = 2'd0;
    localparam logic [1:0] CMD_PARTICLE = 2'd1;
    localparam logic [1:0] CMD_EOE      = 2'd2;
    localparam logic [1:0] CMD_REPORT   = 2'd3;

    localparam logic REG_HALF_WINDOW = 1'b0;
    localparam logic REG_WANTED_CODE = 1'b1;

    localparam logic [2:0] OP_MEAN = 3'd0;
    localparam logic [2:0] OP_NQ   = 3'd1;
    localparam logic [2:0] OP_SS   = 3'd2;
    localparam logic [2:0] OP_NN   = 3'd3;
    localparam logic [2:0] OP_VAR  = 3'd4;
    localparam logic [2:0] OP_SQRT = 3'd5;

    localparam logic signed [17:0] CENTRES [CENTRE_COUNT] = '{
        18'sd18308, 18'sd18414, 18'sd19075, 18'sd19181, 18'sd19842, 18'sd19948,
        18'sd20609, 18'sd20715, 18'sd21376, 18'sd21482, 18'sd22143, 18'sd22249,
        18'sd22910, 18'sd23016, 18'sd23677, 18'sd23783, 18'sd24444, 18'sd24550,
        18'sd25211, 18'sd25317, 18'sd25978, 18'sd26084, 18'sd26745, 18'sd26851,
        18'sd27512, 18'sd27618, 18'sd28279, 18'sd28385
    };

    typedef struct packed {
        logic             count_hit;
        logic             count_part;
        logic             acc_rd;
        logic             acc_wr;
        logic             evt_clear;
        logic             evt_inc;
        logic             op_start;
        logic [2:0]       op;
        logic             out_emit;
        logic             tot;
        logic             last;
        logic             src;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic arith_busy;
        logic evt_full;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/los_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module los_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== design/los_ctrl.sv =====
// Controller state machine sequencing counting, end of event and report walks.
`default_nettype none
module los_ctrl #(
    parameter int LAYER_COUNT = los_pkg::DEF_LAYER_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_cmd,
    input  los_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output los_pkg::t_dp_cmd  o_dp
);
    import los_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EOE_RD = 3'd1;
    localparam logic [2:0] S_EOE_WR = 3'd2;
    localparam logic [2:0] S_REP_RD = 3'd3;
    localparam logic [2:0] S_OP     = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAYER_COUNT);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_src, n_src;
    logic [2:0]       r_op, n_op;
    logic             tot;

    assign tot    = (r_idx == LAST_IDX);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_src   = r_src;
        n_op    = r_op;
        o_dp      = '0;
        o_dp.idx  = r_idx;
        o_dp.src  = r_src;
        o_dp.op   = r_op;
        o_dp.tot  = tot;
        o_dp.last = r_src && tot;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        CMD_HIT:      o_dp.count_hit = 1'b1;
                        CMD_PARTICLE: o_dp.count_part = 1'b1;
                        CMD_EOE: begin
                            if (i_stat.evt_full) begin
                                o_dp.evt_clear = 1'b1;
                            end else begin
                                n_state = S_EOE_RD;
                                n_idx   = '0;
                            end
                        end
                        CMD_REPORT: begin
                            n_state = S_REP_RD;
                            n_idx   = '0;
                            n_src   = 1'b0;
                        end
                    endcase
                end
            end
            S_EOE_RD: begin
                o_dp.acc_rd = 1'b1;
                n_state     = S_EOE_WR;
            end
            S_EOE_WR: begin
                o_dp.acc_wr = 1'b1;
                if (tot) begin
                    o_dp.evt_clear = 1'b1;
                    o_dp.evt_inc   = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_EOE_RD;
                end
            end
            S_REP_RD: begin
                o_dp.acc_rd = 1'b1;
                n_op        = OP_MEAN;
                n_state     = S_OP;
            end
            S_OP: begin
                o_dp.op_start = 1'b1;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (!i_stat.arith_busy) begin
                    if (r_op == OP_SQRT) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_OP;
                        unique case (r_op)
                            OP_MEAN: n_op = OP_NQ;
                            OP_NQ:   n_op = OP_SS;
                            OP_SS:   n_op = OP_NN;
                            OP_NN:   n_op = OP_VAR;
                            default: n_op = OP_SQRT;
                        endcase
                    end
                end
            end
            S_OUT: begin
                o_dp.out_emit = 1'b1;
                n_state       = S_REP_RD;
                if (tot) begin
                    n_idx = '0;
                    if (r_src) begin
                        n_state = S_IDLE;
                    end else begin
                        n_src = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_src   <= 1'b0;
            r_op    <= OP_MEAN;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_src   <= n_src;
            r_op    <= n_op;
        end
    end

    a_report_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_REPORT) |=> o_busy)
        else $error("Report command did not start the walk.");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("Layer index ran past the total entry.");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp.acc_wr |-> $past(o_dp.acc_rd))
        else $error("Accumulator written without a preceding read.");
endmodule
`default_nettype wire

// ===== design/los_datapath.sv =====
// Datapath: layer matching, event counters, accumulators and the shared arithmetic unit.
`default_nettype none
module los_datapath #(
    parameter int LAYER_COUNT = los_pkg::DEF_LAYER_COUNT,
    parameter int MAX_EVENTS  = los_pkg::DEF_MAX_EVENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  los_pkg::t_dp_cmd   i_dp,
    output los_pkg::t_dp_stat  o_stat,
    input  logic signed [16:0] i_x_pos,
    input  logic signed [31:0] i_particle_code,
    input  logic [7:0]         i_half_window,
    input  logic signed [31:0] i_wanted_code,
    output logic               o_strobe,
    output logic               o_source,
    output logic [4:0]         o_layer,
    output logic [23:0]        o_mean,
    output logic [23:0]        o_std_dev,
    output logic               o_last
);
    import los_pkg::*;

    localparam int DEPTH      = LAYER_COUNT + 1;
    localparam int AW         = $clog2(DEPTH);
    localparam int RW         = SQ_W + SUM_W;
    localparam int MUL_STEPS  = 3;
    localparam int DIV_STEPS  = 90;
    localparam int SQRT_STEPS = 24;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Layer matching
    logic signed [17:0]     x_ext, h_ext;
    logic [LAYER_COUNT-1:0] match, pick;
    logic                   any_match, code_ok;

    assign x_ext = 18'(i_x_pos);
    assign h_ext = signed'({10'd0, i_half_window});

    for (genvar g = 0; g < LAYER_COUNT; g++) begin : g_match
        if (g < CENTRE_COUNT) begin : g_win
            assign match[g] = (x_ext > CENTRES[g] - h_ext) && (x_ext <= CENTRES[g] + h_ext);
        end else begin : g_none
            assign match[g] = 1'b0;
        end
    end

    assign pick      = match & (~match + LAYER_COUNT'(1));
    assign any_match = |match;
    assign code_ok   = (i_particle_code == i_wanted_code);

    // Per-event counters
    logic [15:0]      r_hit_cnt [LAYER_COUNT];
    logic [15:0]      r_part_cnt [LAYER_COUNT];
    logic [15:0]      r_hit_tot, r_part_tot;
    logic [EVT_W-1:0] r_events;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAYER_COUNT; i++) begin
                r_hit_cnt[i]  <= '0;
                r_part_cnt[i] <= '0;
            end
            r_hit_tot  <= '0;
            r_part_tot <= '0;
        end else if (i_dp.evt_clear) begin
            for (int i = 0; i < LAYER_COUNT; i++) begin
                r_hit_cnt[i]  <= '0;
                r_part_cnt[i] <= '0;
            end
            r_hit_tot  <= '0;
            r_part_tot <= '0;
        end else if (i_dp.acc_wr && !i_dp.tot) begin
            for (int i = 0; i < LAYER_COUNT - 1; i++) begin
                r_hit_cnt[i]  <= r_hit_cnt[i+1];
                r_part_cnt[i] <= r_part_cnt[i+1];
            end
            r_hit_cnt[LAYER_COUNT-1]  <= '0;
            r_part_cnt[LAYER_COUNT-1] <= '0;
        end else begin
            if (i_dp.count_hit && any_match) begin
                for (int i = 0; i < LAYER_COUNT; i++) begin
                    if (pick[i]) begin
                        r_hit_cnt[i] <= inc16(r_hit_cnt[i]);
                    end
                end
                r_hit_tot <= inc16(r_hit_tot);
            end
            if (i_dp.count_part && code_ok) begin
                for (int i = 0; i < LAYER_COUNT; i++) begin
                    if (pick[i]) begin
                        r_part_cnt[i] <= inc16(r_part_cnt[i]);
                    end
                end
                r_part_tot <= inc16(r_part_tot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_events <= '0;
        end else if (i_dp.evt_inc) begin
            r_events <= r_events + 1'b1;
        end
    end

    // Accumulator memories, rows marked valid once written
    logic [AW-1:0]     addr;
    logic [RW-1:0]     hit_rdata, part_rdata, hit_wdata, part_wdata;
    logic [DEPTH-1:0]  r_valid;
    logic              r_rvalid;
    logic [SUM_W-1:0]  hit_s, part_s, op_s;
    logic [SQ_W-1:0]   hit_q, part_q, op_q;
    logic [15:0]       c_hit, c_part;
    logic [31:0]       c_hit_sq, c_part_sq;
    logic [SUM_W:0]    hit_s_sum, part_s_sum;
    logic [SQ_W:0]     hit_q_sum, part_q_sum;

    assign addr  = i_dp.idx[AW-1:0];
    assign hit_s  = r_rvalid ? hit_rdata[SUM_W-1:0] : '0;
    assign hit_q  = r_rvalid ? hit_rdata[RW-1:SUM_W] : '0;
    assign part_s = r_rvalid ? part_rdata[SUM_W-1:0] : '0;
    assign part_q = r_rvalid ? part_rdata[RW-1:SUM_W] : '0;
    assign op_s   = i_dp.src ? part_s : hit_s;
    assign op_q   = i_dp.src ? part_q : hit_q;

    assign c_hit      = i_dp.tot ? r_hit_tot : r_hit_cnt[0];
    assign c_part     = i_dp.tot ? r_part_tot : r_part_cnt[0];
    assign c_hit_sq   = c_hit * c_hit;
    assign c_part_sq  = c_part * c_part;
    assign hit_s_sum  = {1'b0, hit_s} + (SUM_W + 1)'(c_hit);
    assign part_s_sum = {1'b0, part_s} + (SUM_W + 1)'(c_part);
    assign hit_q_sum  = {1'b0, hit_q} + (SQ_W + 1)'(c_hit_sq);
    assign part_q_sum = {1'b0, part_q} + (SQ_W + 1)'(c_part_sq);
    assign hit_wdata  = {hit_q_sum[SQ_W] ? {SQ_W{1'b1}} : hit_q_sum[SQ_W-1:0],
                         hit_s_sum[SUM_W] ? {SUM_W{1'b1}} : hit_s_sum[SUM_W-1:0]};
    assign part_wdata = {part_q_sum[SQ_W] ? {SQ_W{1'b1}} : part_q_sum[SQ_W-1:0],
                         part_s_sum[SUM_W] ? {SUM_W{1'b1}} : part_s_sum[SUM_W-1:0]};

    los_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_hit_acc (
        .i_clk   (i_clk),
        .i_we    (i_dp.acc_wr),
        .i_waddr (addr),
        .i_wdata (hit_wdata),
        .i_re    (i_dp.acc_rd),
        .i_raddr (addr),
        .o_rdata (hit_rdata)
    );

    los_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_part_acc (
        .i_clk   (i_clk),
        .i_we    (i_dp.acc_wr),
        .i_waddr (addr),
        .i_wdata (part_wdata),
        .i_re    (i_dp.acc_rd),
        .i_raddr (addr),
        .o_rdata (part_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_dp.acc_wr) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_dp.acc_rd) begin
                r_rvalid <= r_valid[addr];
            end
        end
    end

    // Shared arithmetic unit: chunked multiplier, restoring divider, square root
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [2:0]  r_op;
    logic [87:0] r_p, n_p;
    logic [51:0] r_ma;
    logic [35:0] r_mb;
    logic [89:0] r_dvd;
    logic [41:0] r_dvs;
    logic [42:0] r_rem, rem_sh, n_rem;
    logic [47:0] r_q, n_q;
    logic        r_qovf, n_qovf, div_ge;
    logic [47:0] r_sx;
    logic [24:0] r_srem;
    logic [26:0] srem_sh, strial;
    logic [23:0] r_root, n_root;
    logic        sq_ge;
    logic [23:0] r_mean, r_sd;
    logic [73:0] r_nq, var_v;
    logic [71:0] r_ss;
    logic [41:0] r_nn;
    logic [47:0] r_var;

    assign n_p     = {r_p[75:0], 12'd0} + 88'(r_ma * r_mb[35:24]);
    assign rem_sh  = {r_rem[41:0], r_dvd[89]};
    assign div_ge  = (rem_sh >= {1'b0, r_dvs});
    assign n_rem   = div_ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
    assign n_q     = {r_q[46:0], div_ge};
    assign n_qovf  = r_qovf | r_q[47];
    assign srem_sh = {r_srem, r_sx[47:46]};
    assign strial  = {1'b0, r_root, 2'b01};
    assign sq_ge   = (srem_sh >= strial);
    assign n_root  = {r_root[22:0], sq_ge};
    assign var_v   = (r_nq >= 74'(r_ss)) ? r_nq - 74'(r_ss) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MEAN;
        end else if (i_dp.op_start) begin
            r_busy <= 1'b1;
            r_op   <= i_dp.op;
            unique case (i_dp.op)
                OP_MEAN, OP_VAR: r_cnt <= 7'(DIV_STEPS - 1);
                OP_SQRT:         r_cnt <= 7'(SQRT_STEPS - 1);
                default:         r_cnt <= 7'(MUL_STEPS - 1);
            endcase
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.op_start) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
            r_p    <= '0;
            r_srem <= '0;
            r_root <= '0;
            r_sx   <= r_var;
            r_dvs  <= 42'(r_events);
            r_dvd  <= 90'({op_s, 8'd0});
            r_ma   <= op_q;
            r_mb   <= 36'(r_events);
            unique case (i_dp.op)
                OP_SS: begin
                    r_ma <= 52'(op_s);
                    r_mb <= op_s;
                end
                OP_NN:   r_ma <= 52'(r_events);
                OP_VAR: begin
                    r_dvd <= {var_v, 16'd0};
                    r_dvs <= r_nn;
                end
                default: ;
            endcase
        end else if (r_busy) begin
            r_p    <= n_p;
            r_mb   <= {r_mb[23:0], 12'd0};
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[88:0], 1'b0};
            r_q    <= n_q;
            r_qovf <= n_qovf;
            r_srem <= sq_ge ? 25'(srem_sh - strial) : 25'(srem_sh);
            r_root <= n_root;
            r_sx   <= {r_sx[45:0], 2'b00};
            if (r_cnt == '0) begin
                unique case (r_op)
                    OP_MEAN: r_mean <= (n_qovf || (|n_q[47:24])) ? '1 : n_q[23:0];
                    OP_NQ:   r_nq   <= n_p[73:0];
                    OP_SS:   r_ss   <= n_p[71:0];
                    OP_NN:   r_nn   <= n_p[41:0];
                    OP_VAR:  r_var  <= n_qovf ? '1 : n_q;
                    OP_SQRT: r_sd   <= n_root;
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.arith_busy = r_busy;
    assign o_stat.evt_full   = (r_events >= EVT_W'(MAX_EVENTS));

    // Result register
    logic        r_strobe, r_source, r_last;
    logic [4:0]  r_layer;
    logic [23:0] r_omean, r_osd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_dp.out_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.out_emit) begin
            r_source <= i_dp.src;
            r_layer  <= i_dp.idx[4:0];
            r_last   <= i_dp.last;
            r_omean  <= (r_events == '0) ? '0 : r_mean;
            r_osd    <= (r_events == '0) ? '0 : r_sd;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_source  = r_source;
    assign o_layer   = r_layer;
    assign o_mean    = r_omean;
    assign o_std_dev = r_osd;
    assign o_last    = r_last;
endmodule
`default_nettype wire

// ===== design/layer_occupancy_statistics.sv =====
// Top level of the layer occupancy statistics block with its register port.
//
// A hit or particle beat is counted in the cycle it is accepted, so these may
// follow one another on every clock while idle. An end of event walks the
// LAYER_COUNT+1 accumulator rows of the memory, reading then writing each row,
// or only clears the counters once MAX_EVENTS events are counted. A report
// emits 2*(LAYER_COUNT+1) results, one strobe each, using the shared divider's
// 90 steps for the mean and 90 for the variance, 24 square root steps and the
// chunked products; the receiver cannot stall, so results leave as computed.
`default_nettype none
module layer_occupancy_statistics #(
    parameter int LAYER_COUNT = los_pkg::DEF_LAYER_COUNT,
    parameter int MAX_EVENTS  = los_pkg::DEF_MAX_EVENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [16:0] i_x_pos,
    input  logic signed [31:0] i_particle_code,
    output logic               o_strobe,
    output logic               o_source,
    output logic [4:0]         o_layer,
    output logic [23:0]        o_mean,
    output logic [23:0]        o_std_dev,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import los_pkg::*;

    logic               cfg_wr;
    logic [7:0]         r_half_window;
    logic signed [31:0] r_wanted_code;
    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= 8'd50;
            r_wanted_code <= -32'sd22;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HALF_WINDOW) begin
                r_half_window <= pwdata[7:0];
            end else begin
                r_wanted_code <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_WANTED_CODE) ? r_wanted_code : {24'd0, r_half_window};

    los_ctrl #(.LAYER_COUNT(LAYER_COUNT)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_dp    (dp_cmd)
    );

    los_datapath #(.LAYER_COUNT(LAYER_COUNT), .MAX_EVENTS(MAX_EVENTS)) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp            (dp_cmd),
        .o_stat          (dp_stat),
        .i_x_pos         (i_x_pos),
        .i_particle_code (i_particle_code),
        .i_half_window   (r_half_window),
        .i_wanted_code   (r_wanted_code),
        .o_strobe        (o_strobe),
        .o_source        (o_source),
        .o_layer         (o_layer),
        .o_mean          (o_mean),
        .o_std_dev       (o_std_dev),
        .o_last          (o_last)
    );
endmodule
`default_nettype wire
